### hdl/two_class_front_back_queue_defines.svh
// Assertion macros used by the checker file of the queue.
`ifndef TWO_CLASS_FRONT_BACK_QUEUE_DEFINES_SVH
`define TWO_CLASS_FRONT_BACK_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TFBQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TFBQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tfbq_pkg.sv
package tfbq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;

	localparam int ID_W      = 16;
	localparam int AGE_W     = 8;
	localparam int CNT_OUT_W = 5;
	localparam int ENTRY_W   = 1 + AGE_W + ID_W;

	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_SERVE = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_READ
	} state_t;

	// Layout of one stored entry: urgent flag on top, then age, then id.
	typedef struct packed {
		logic             urgent;
		logic [AGE_W-1:0] age;
		logic [ID_W-1:0]  id;
	} entry_t;

	// One result item as it travels from the controller to the output register.
	typedef struct packed {
		logic                 served_valid;
		logic [ID_W-1:0]      served_id;
		logic [AGE_W-1:0]     served_age;
		logic                 served_urgent;
		logic                 was_empty;
		logic                 dropped_full;
		logic [CNT_OUT_W-1:0] total_count;
		logic [CNT_OUT_W-1:0] urgent_count;
		logic [CNT_OUT_W-1:0] regular_count;
	} result_t;

endpackage

### hdl/tfbq_ram.sv
module tfbq_ram #(
	parameter int WIDTH = tfbq_pkg::ENTRY_W,
	parameter int DEPTH = tfbq_pkg::DEFAULT_QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/tfbq_ctrl.sv
module tfbq_ctrl #(
	parameter int QUEUE_DEPTH = tfbq_pkg::DEFAULT_QUEUE_DEPTH,
	localparam int IDX_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic                          command,
	input  logic [tfbq_pkg::ID_W-1:0]     entry_id,
	input  logic [tfbq_pkg::AGE_W-1:0]    entry_age,
	input  logic                          urgent,
	output logic                          ram_we,
	output logic [IDX_W-1:0]              ram_waddr,
	output logic [tfbq_pkg::ENTRY_W-1:0]  ram_wdata,
	output logic                          ram_re,
	output logic [IDX_W-1:0]              ram_raddr,
	input  logic [tfbq_pkg::ENTRY_W-1:0]  ram_rdata,
	output logic                          busy,
	output logic                          res_load,
	output tfbq_pkg::result_t             res
);

	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

	tfbq_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] total_q, total_d, urg_q, urg_d, reg_q, reg_d;
	tfbq_pkg::entry_t new_entry, rd_entry;

	function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] s);
		return (s == '0) ? LAST_SLOT : s - 1'b1;
	endfunction

	// Counts are reported in the low bits only.
	function automatic logic [tfbq_pkg::CNT_OUT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
		logic [CNT_W+tfbq_pkg::CNT_OUT_W-1:0] ext;
		ext = {{tfbq_pkg::CNT_OUT_W{1'b0}}, c};
		return ext[tfbq_pkg::CNT_OUT_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfbq_pkg::ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
			urg_q   <= '0;
			reg_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			total_q <= total_d;
			urg_q   <= urg_d;
			reg_q   <= reg_d;
		end
	end

	always_comb begin
		new_entry.urgent = urgent;
		new_entry.age    = entry_age;
		new_entry.id     = entry_id;
		rd_entry         = tfbq_pkg::entry_t'(ram_rdata);

		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		total_d   = total_q;
		urg_d     = urg_q;
		reg_d     = reg_q;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = new_entry;
		ram_re    = 1'b0;
		ram_raddr = head_q;
		res_load  = 1'b0;
		res       = '0;

		unique case (state_q)
			tfbq_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (command == tfbq_pkg::CMD_ADMIT) begin
						res_load = 1'b1;
						if (total_q == FULL_CNT) begin
							res.dropped_full = 1'b1;
						end else begin
							ram_we  = 1'b1;
							total_d = total_q + 1'b1;
							if (urgent) begin
								head_d    = slot_prev(head_q);
								ram_waddr = head_d;
								urg_d     = urg_q + 1'b1;
							end else begin
								tail_d = slot_next(tail_q);
								reg_d  = reg_q + 1'b1;
							end
						end
					end else if (total_q == '0) begin
						res_load      = 1'b1;
						res.was_empty = 1'b1;
					end else begin
						ram_re  = 1'b1;
						state_d = tfbq_pkg::ST_READ;
					end
				end
			end
			tfbq_pkg::ST_READ: begin
				res_load          = 1'b1;
				res.served_valid  = 1'b1;
				res.served_id     = rd_entry.id;
				res.served_age    = rd_entry.age;
				res.served_urgent = rd_entry.urgent;
				head_d            = slot_next(head_q);
				total_d           = total_q - 1'b1;
				if (rd_entry.urgent) begin
					if (urg_q != '0) begin
						urg_d = urg_q - 1'b1;
					end
				end else if (reg_q != '0) begin
					reg_d = reg_q - 1'b1;
				end
				state_d = tfbq_pkg::ST_IDLE;
			end
			default: state_d = tfbq_pkg::ST_IDLE;
		endcase

		res.total_count   = cnt_out(total_d);
		res.urgent_count  = cnt_out(urg_d);
		res.regular_count = cnt_out(reg_d);
	end

	assign busy = (state_q != tfbq_pkg::ST_IDLE);

endmodule

### hdl/two_class_front_back_queue.sv
// An admit or a serve on an empty queue loads its result into the output register
// directly; a serve that returns an entry first reads the entry memory, then loads it.
// Throughput: one admit per cycle while the output channel does not stall; a returning
// serve blocks new input while the registered read of the entry memory completes.
// Reset (arst_n low, asynchronous): queue empty, pointers and counts zero, no result.
module two_class_front_back_queue #(
	parameter int QUEUE_DEPTH = tfbq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [tfbq_pkg::ID_W-1:0]         entry_id,
	input  logic [tfbq_pkg::AGE_W-1:0]        entry_age,
	input  logic                              urgent,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              served_valid,
	output logic [tfbq_pkg::ID_W-1:0]         served_id,
	output logic [tfbq_pkg::AGE_W-1:0]        served_age,
	output logic                              served_urgent,
	output logic                              was_empty,
	output logic                              dropped_full,
	output logic [tfbq_pkg::CNT_OUT_W-1:0]    total_count,
	output logic [tfbq_pkg::CNT_OUT_W-1:0]    urgent_count,
	output logic [tfbq_pkg::CNT_OUT_W-1:0]    regular_count
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	// The entries live in a single ring-buffer memory. Urgent entries are written one
	// slot below the head pointer and regular ones at the tail pointer, so the head
	// slot is always the next entry to serve.
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [tfbq_pkg::ENTRY_W-1:0]  ram_wdata;
	logic                          ram_re;
	logic [IDX_W-1:0]              ram_raddr;
	logic [tfbq_pkg::ENTRY_W-1:0]  ram_rdata;

	logic              ctrl_busy;
	logic              res_load;
	tfbq_pkg::result_t ctrl_res;

	// Output register. It separates the two channels: a new input transfer can be
	// taken in the same cycle that the waiting result is transferred out.
	logic              out_valid_q;
	tfbq_pkg::result_t res_q;
	logic              out_free;
	logic              in_fire;

	assign out_free = !out_valid_q || !out_stall;

	// While a serve waits for its memory read, no new item is taken. Otherwise a new
	// item is taken whenever the output register will have room for a result at the
	// next edge. A serve that reads memory only loads the output register in the cycle
	// after it is taken, and nothing else can fill the register in between.
	assign in_stall = ctrl_busy || !out_free;
	assign in_fire  = in_valid && !in_stall;

	tfbq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.command   (command),
		.entry_id  (entry_id),
		.entry_age (entry_age),
		.urgent    (urgent),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.busy      (ctrl_busy),
		.res_load  (res_load),
		.res       (ctrl_res)
	);

	tfbq_ram #(
		.WIDTH (tfbq_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Valid flag of the output register; a load wins over the drain of the old result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset; it only changes when a new result is loaded.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= ctrl_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign served_valid  = res_q.served_valid;
	assign served_id     = res_q.served_id;
	assign served_age    = res_q.served_age;
	assign served_urgent = res_q.served_urgent;
	assign was_empty     = res_q.was_empty;
	assign dropped_full  = res_q.dropped_full;
	assign total_count   = res_q.total_count;
	assign urgent_count  = res_q.urgent_count;
	assign regular_count = res_q.regular_count;

endmodule

### hdl/tfbq_checker.sv
`include "two_class_front_back_queue_defines.svh"

module tfbq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           served_valid,
	input logic [tfbq_pkg::ID_W-1:0]      served_id,
	input logic [tfbq_pkg::AGE_W-1:0]     served_age,
	input logic                           served_urgent,
	input logic                           was_empty,
	input logic                           dropped_full,
	input logic [tfbq_pkg::CNT_OUT_W-1:0] total_count,
	input logic [tfbq_pkg::CNT_OUT_W-1:0] urgent_count,
	input logic [tfbq_pkg::CNT_OUT_W-1:0] regular_count
);

	// A result is at most one of: a served entry, an empty serve, a dropped admit.
	`TFBQ_ASSERT_SAME(a_one_outcome, out_valid, $countones({served_valid, was_empty, dropped_full}) <= 1, "result carries more than one outcome")

	// The two class counts always add up to the total count.
	`TFBQ_ASSERT_SAME(a_count_sum, out_valid, total_count == tfbq_pkg::CNT_OUT_W'(urgent_count + regular_count), "class counts do not add up to total")

	// Without a served entry the served fields read zero.
	`TFBQ_ASSERT_SAME(a_idle_fields, out_valid && !served_valid, served_id == '0 && served_age == '0 && served_urgent == 1'b0, "served fields set without a served entry")

	// A stalled result holds its payload.
	`TFBQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(served_id) && $stable(total_count), "stalled result changed")

endmodule

bind two_class_front_back_queue tfbq_checker u_tfbq_checker (.*);
